// ----- hw/rtl/nnot_pkg.sv -----
// shared types and constants for the nearest neighbour object tracker
`timescale 1ns / 1ps

package nnot_pkg;

    localparam int LABEL_W    = 16;
    localparam int DIST_W     = 25;
    localparam int INLET_W    = 12;
    localparam int GATE_W     = 8;
    localparam int GATE_SQ_W  = 2 * GATE_W;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 12;

    localparam logic [LABEL_W-1:0] LABEL_MAX    = 16'hFFFF;
    localparam logic [DIST_W-1:0]  DIST_MAX     = 25'h1FF_FFFF;
    localparam int                 INLET_MARGIN = 5;

    localparam logic [INLET_W-1:0] INLET_RESET     = 12'd0;
    localparam logic [GATE_W-1:0]  NEAR_GATE_RESET = 8'd5;
    localparam logic [GATE_W-1:0]  FAR_GATE_RESET  = 8'd20;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_INLET_X   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_NEAR_GATE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FAR_GATE  = 2'd2;

    // input op codes
    localparam logic OP_OBJECT = 1'b0;
    localparam logic OP_EOF    = 1'b1;

    typedef struct packed {
        logic capture;
        logic eof;
        logic issue;
        logic finish;
    } cmd_t;

    typedef struct packed {
        logic prev_empty;
        logic issue_last;
        logic pipe_busy;
        logic out_free;
    } status_t;

endpackage

// ----- hw/rtl/nnot_ram.sv -----
// generic single write port ram with registered read
`timescale 1ns / 1ps

module nnot_ram #(
    parameter int WIDTH = 40,
    parameter int DEPTH = 128
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- hw/rtl/nnot_ctrl.sv -----
// sequencing state machine for the tracker
`timescale 1ns / 1ps

module nnot_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    input  logic             op,
    output logic             in_stall,
    input  nnot_pkg::status_t status,
    output nnot_pkg::cmd_t    cmd
);

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_SCAN   = 4'b0010,
        ST_DRAIN  = 4'b0100,
        ST_FINISH = 4'b1000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    if (op == nnot_pkg::OP_EOF)
                    begin
                        cmd.eof = 1'b1;
                    end
                    else
                    begin
                        cmd.capture = 1'b1;
                        state_next  = status.prev_empty ? ST_FINISH : ST_SCAN;
                    end
                end
            end
            ST_SCAN:
            begin
                cmd.issue = 1'b1;
                if (status.issue_last)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (!status.pipe_busy)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (status.out_free)
                begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign in_stall = (state_reg != ST_IDLE);

endmodule

// ----- hw/rtl/nnot_dp.sv -----
// datapath: object banks, distance pipeline, gate decision and result register
`timescale 1ns / 1ps

module nnot_dp #(
    parameter int MAX_OBJECTS = 64,
    parameter int COORD_BITS  = 12
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  nnot_pkg::cmd_t                      cmd,
    output nnot_pkg::status_t                   status,
    input  logic [COORD_BITS-1:0]               obj_x,
    input  logic [COORD_BITS-1:0]               obj_y,
    input  logic                                cfg_we,
    input  logic [nnot_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [nnot_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  logic                                out_stall,
    output logic                                out_valid,
    output logic [nnot_pkg::LABEL_W-1:0]        track_label,
    output logic                                is_new,
    output logic [nnot_pkg::DIST_W-1:0]         nearest_dist_sq,
    output logic                                table_full
);

    localparam int IW        = (MAX_OBJECTS > 1) ? $clog2(MAX_OBJECTS) : 1;
    localparam int CW        = $clog2(MAX_OBJECTS + 1);
    localparam int RAM_DEPTH = 2 * (1 << IW);
    localparam int LW        = nnot_pkg::LABEL_W;
    localparam int ENTRY_W   = 2 * COORD_BITS + LW;
    localparam int SQ_W      = 2 * COORD_BITS;
    localparam int BW        = (SQ_W + 1 > nnot_pkg::DIST_W) ? SQ_W + 1 : nnot_pkg::DIST_W;
    localparam int CMP_W     = ((COORD_BITS > nnot_pkg::INLET_W) ?
                                COORD_BITS : nnot_pkg::INLET_W) + 1;

    // configuration
    logic [nnot_pkg::INLET_W-1:0] inlet_reg;
    logic [nnot_pkg::GATE_W-1:0]  near_gate_reg;
    logic [nnot_pkg::GATE_W-1:0]  far_gate_reg;

    // control state
    logic [CW-1:0]  prev_count_reg;
    logic [CW-1:0]  cur_count_reg;
    logic [LW-1:0]  next_label_reg;
    logic           bank_reg;
    logic [IW-1:0]  idx_reg;
    logic           v1_reg;
    logic           v2_reg;
    logic           out_valid_reg;

    // payload
    logic [COORD_BITS-1:0]          x_reg;
    logic [COORD_BITS-1:0]          y_reg;
    logic [nnot_pkg::GATE_SQ_W-1:0] gate_sq_reg;
    logic                           first1_reg;
    logic                           first2_reg;
    logic [SQ_W-1:0]                sqx_reg;
    logic [SQ_W-1:0]                sqy_reg;
    logic [LW-1:0]                  lab2_reg;
    logic [BW-1:0]                  best_reg;
    logic [LW-1:0]                  best_label_reg;
    logic [LW-1:0]                  label_out_reg;
    logic                           is_new_out_reg;
    logic [nnot_pkg::DIST_W-1:0]    dist_out_reg;
    logic                           full_out_reg;

    logic [ENTRY_W-1:0]    rd_data;
    logic [COORD_BITS-1:0] rd_x;
    logic [COORD_BITS-1:0] rd_y;
    logic [LW-1:0]         rd_label;
    logic [COORD_BITS-1:0] dx;
    logic [COORD_BITS-1:0] dy;
    logic [BW-1:0]         dist_sum;
    logic                  near_region;
    logic [nnot_pkg::GATE_W-1:0] gate;
    logic                  prev_empty;
    logic                  cur_full;
    logic                  decide_new;
    logic [LW-1:0]         decide_label;
    logic [nnot_pkg::DIST_W-1:0] dist_sat;

    nnot_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (RAM_DEPTH)
    ) u_bank_ram (
        .clk   (clk),
        .we    (cmd.finish && !cur_full),
        .waddr ({bank_reg, cur_count_reg[IW-1:0]}),
        .wdata ({x_reg, y_reg, decide_label}),
        .re    (cmd.issue),
        .raddr ({~bank_reg, idx_reg}),
        .rdata (rd_data)
    );

    assign rd_x     = rd_data[ENTRY_W-1 -: COORD_BITS];
    assign rd_y     = rd_data[LW +: COORD_BITS];
    assign rd_label = rd_data[LW-1:0];

    assign dx = (rd_x >= x_reg) ? (rd_x - x_reg) : (x_reg - rd_x);
    assign dy = (rd_y >= y_reg) ? (rd_y - y_reg) : (y_reg - rd_y);

    assign dist_sum = BW'(sqx_reg) + BW'(sqy_reg);

    // near gate applies when x + margin <= inlet
    assign near_region = (CMP_W'(obj_x) + CMP_W'(nnot_pkg::INLET_MARGIN))
                         <= CMP_W'(inlet_reg);
    assign gate        = near_region ? near_gate_reg : far_gate_reg;

    assign prev_empty   = (prev_count_reg == '0);
    assign cur_full     = (cur_count_reg == CW'(MAX_OBJECTS));
    assign decide_new   = prev_empty || (best_reg > BW'(gate_sq_reg));
    assign decide_label = decide_new ? next_label_reg : best_label_reg;
    assign dist_sat     = prev_empty ? '0 :
                          (best_reg > BW'(nnot_pkg::DIST_MAX)) ? nnot_pkg::DIST_MAX :
                          best_reg[nnot_pkg::DIST_W-1:0];

    assign status.prev_empty = prev_empty;
    assign status.issue_last = ((CW'(idx_reg) + CW'(1)) == prev_count_reg);
    assign status.pipe_busy  = v1_reg || v2_reg;
    assign status.out_free   = !out_valid_reg || !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inlet_reg      <= nnot_pkg::INLET_RESET;
            near_gate_reg  <= nnot_pkg::NEAR_GATE_RESET;
            far_gate_reg   <= nnot_pkg::FAR_GATE_RESET;
            prev_count_reg <= '0;
            cur_count_reg  <= '0;
            next_label_reg <= '0;
            bank_reg       <= 1'b0;
            idx_reg        <= '0;
            v1_reg         <= 1'b0;
            v2_reg         <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    nnot_pkg::CFG_INLET_X:   inlet_reg     <= cfg_data;
                    nnot_pkg::CFG_NEAR_GATE: near_gate_reg <= cfg_data[nnot_pkg::GATE_W-1:0];
                    nnot_pkg::CFG_FAR_GATE:  far_gate_reg  <= cfg_data[nnot_pkg::GATE_W-1:0];
                    default:                 ;
                endcase
            end

            if (cmd.eof)
            begin
                prev_count_reg <= cur_count_reg;
                cur_count_reg  <= '0;
                bank_reg       <= ~bank_reg;
            end

            if (cmd.capture)
            begin
                idx_reg <= '0;
            end
            else if (cmd.issue)
            begin
                idx_reg <= idx_reg + IW'(1);
            end

            v1_reg <= cmd.issue;
            v2_reg <= v1_reg;

            if (cmd.finish)
            begin
                out_valid_reg <= 1'b1;
                if (!cur_full)
                begin
                    cur_count_reg <= cur_count_reg + CW'(1);
                end
                if (decide_new && (next_label_reg != nnot_pkg::LABEL_MAX))
                begin
                    next_label_reg <= next_label_reg + LW'(1);
                end
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            x_reg       <= obj_x;
            y_reg       <= obj_y;
            gate_sq_reg <= nnot_pkg::GATE_SQ_W'(gate) * nnot_pkg::GATE_SQ_W'(gate);
        end
        if (cmd.issue)
        begin
            first1_reg <= (idx_reg == '0);
        end
        if (v1_reg)
        begin
            sqx_reg    <= SQ_W'(dx) * SQ_W'(dx);
            sqy_reg    <= SQ_W'(dy) * SQ_W'(dy);
            lab2_reg   <= rd_label;
            first2_reg <= first1_reg;
        end
        // strict less-than keeps the earliest entry on a tie
        if (v2_reg && (first2_reg || (dist_sum < best_reg)))
        begin
            best_reg       <= dist_sum;
            best_label_reg <= lab2_reg;
        end
        if (cmd.finish)
        begin
            label_out_reg  <= decide_label;
            is_new_out_reg <= decide_new;
            dist_out_reg   <= dist_sat;
            full_out_reg   <= cur_full;
        end
    end

    assign out_valid       = out_valid_reg;
    assign track_label     = label_out_reg;
    assign is_new          = is_new_out_reg;
    assign nearest_dist_sq = dist_out_reg;
    assign table_full      = full_out_reg;

    a_drained_at_finish: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |-> !(v1_reg || v2_reg))
        else $error("decision taken with distance pipeline still busy");

    a_scan_needs_entries: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.issue |-> !prev_empty && (CW'(idx_reg) < prev_count_reg))
        else $error("bank read beyond previous frame entries");

    a_count_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        (prev_count_reg <= CW'(MAX_OBJECTS)) && (cur_count_reg <= CW'(MAX_OBJECTS)))
        else $error("object count exceeds bank depth");

    a_finish_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |=> out_valid_reg)
        else $error("result beat lost after decision");

endmodule

// ----- hw/rtl/nearest_neighbour_object_tracker.sv -----
// nearest neighbour gated object tracker, top level
// an object beat is captured and the previous-frame bank is scanned through the pipeline
// to find the best match, then the gate decision is registered as the result beat
// with an empty previous frame the scan is skipped; no new object is taken before the last result
// is registered, as out_stall allows; the bank ram read port scans one stored entry per cycle
// reset clears counts, next label, bank select, valid flags; bank ram and data regs undefined
`timescale 1ns / 1ps

module nearest_neighbour_object_tracker #(
    parameter int MAX_OBJECTS = 64,
    parameter int COORD_BITS  = 12
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic                            op,
    input  logic [COORD_BITS-1:0]           obj_x,
    input  logic [COORD_BITS-1:0]           obj_y,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic [nnot_pkg::LABEL_W-1:0]    track_label,
    output logic                            is_new,
    output logic [nnot_pkg::DIST_W-1:0]     nearest_dist_sq,
    output logic                            table_full,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [nnot_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [nnot_pkg::CFG_DATA_W-1:0] cfg_data
);

    nnot_pkg::cmd_t    cmd;
    nnot_pkg::status_t status;

    assign cfg_ready = 1'b1;

    nnot_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .op       (op),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    nnot_dp #(
        .MAX_OBJECTS (MAX_OBJECTS),
        .COORD_BITS  (COORD_BITS)
    ) u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .status          (status),
        .obj_x           (obj_x),
        .obj_y           (obj_y),
        .cfg_we          (cfg_valid && cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .out_stall       (out_stall),
        .out_valid       (out_valid),
        .track_label     (track_label),
        .is_new          (is_new),
        .nearest_dist_sq (nearest_dist_sq),
        .table_full      (table_full)
    );

endmodule

// ----- dv/nearest_neighbour_object_tracker_tb.sv -----
// self-checking testbench for the nearest neighbour object tracker
`timescale 1ns / 1ps

module nearest_neighbour_object_tracker_tb;

    localparam int MAX_OBJ       = 64;
    localparam int COORD_W       = 12;
    localparam int TOTAL_ITEMS   = 1150;
    localparam int SETTLE_CYCLES = 10;
    localparam int TAIL_CYCLES   = 2 * (MAX_OBJ + 5);
    localparam int CYCLE_LIMIT   = 1_000_000;

    // index with no register behind it, writes to it must change nothing
    localparam logic [nnot_pkg::CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

    typedef struct packed {
        logic [nnot_pkg::LABEL_W-1:0] label;
        logic                         is_new;
        logic [nnot_pkg::DIST_W-1:0]  dsq;
        logic                         full;
    } track_res_t;

    typedef enum logic [1:0] {ROW_OBJECT, ROW_EOF, ROW_CONFIG} row_kind_t;

    typedef struct {
        row_kind_t                         kind;
        logic [COORD_W-1:0]                x;
        logic [COORD_W-1:0]                y;
        logic [nnot_pkg::CFG_IDX_W-1:0]    idx;
        logic [nnot_pkg::CFG_DATA_W-1:0]   data;
        bit                                known;
        track_res_t                        res;
    } stim_row_t;

    logic                              clk;
    logic                              rst_n;
    logic                              in_valid;
    logic                              in_stall;
    logic                              op;
    logic [COORD_W-1:0]                obj_x;
    logic [COORD_W-1:0]                obj_y;
    logic                              out_valid;
    logic                              out_stall = 1'b0;
    logic [nnot_pkg::LABEL_W-1:0]      track_label;
    logic                              is_new;
    logic [nnot_pkg::DIST_W-1:0]       nearest_dist_sq;
    logic                              table_full;
    logic                              cfg_valid;
    logic                              cfg_ready;
    logic [nnot_pkg::CFG_IDX_W-1:0]    cfg_index;
    logic [nnot_pkg::CFG_DATA_W-1:0]   cfg_data;

    // tracker mirror: two banks of stored centroids and a bank select
    logic [COORD_W-1:0]            bank_x   [2][MAX_OBJ];
    logic [COORD_W-1:0]            bank_y   [2][MAX_OBJ];
    logic [nnot_pkg::LABEL_W-1:0]  bank_lbl [2][MAX_OBJ];
    int                            prev_n    = 0;
    int                            cur_n     = 0;
    bit                            bank_sel  = 1'b0;
    logic [nnot_pkg::LABEL_W-1:0]  label_ctr = '0;
    logic [nnot_pkg::INLET_W-1:0]  inlet_q   = nnot_pkg::INLET_RESET;
    logic [nnot_pkg::GATE_W-1:0]   near_q    = nnot_pkg::NEAR_GATE_RESET;
    logic [nnot_pkg::GATE_W-1:0]   far_q     = nnot_pkg::FAR_GATE_RESET;

    track_res_t  expected_tracks [$];
    stim_row_t   plan [$];
    int          fail_count  = 0;
    int          items_sent  = 0;
    int          cycle_count = 0;
    int          stall_left  = 0;
    bit          calm        = 1'b0;
    bit          cfg_open    = 1'b0;

    nearest_neighbour_object_tracker #(
        .MAX_OBJECTS (MAX_OBJ),
        .COORD_BITS  (COORD_W)
    ) u_dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .op              (op),
        .obj_x           (obj_x),
        .obj_y           (obj_y),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .track_label     (track_label),
        .is_new          (is_new),
        .nearest_dist_sq (nearest_dist_sq),
        .table_full      (table_full),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    // mostly short gaps, a few long ones, none at all in calm stretches
    function automatic int pick_gap();
        int r;
        if (calm)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        if (r < 98)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    task automatic track_object(input logic [COORD_W-1:0] x, input logic [COORD_W-1:0] y,
                                output track_res_t r);
        int  pb;
        int  cb;
        int  dx;
        int  dy;
        int  d;
        int  best;
        int  best_i;
        int  gate;
        bit  fresh;
        cb     = bank_sel ? 1 : 0;
        pb     = bank_sel ? 0 : 1;
        fresh  = 1'b1;
        best   = 0;
        best_i = 0;
        if (prev_n != 0)
        begin
            for (int i = 0; i < prev_n; i++)
            begin
                dx = int'(x) - int'(bank_x[pb][i]);
                dy = int'(y) - int'(bank_y[pb][i]);
                d  = dx * dx + dy * dy;
                // strict compare keeps the first of equal distances
                if (i == 0 || d < best)
                begin
                    best   = d;
                    best_i = i;
                end
            end
            gate  = (int'(x) + nnot_pkg::INLET_MARGIN <= int'(inlet_q)) ?
                    int'(near_q) : int'(far_q);
            fresh = (best > gate * gate);
        end
        if (fresh)
        begin
            r.label = label_ctr;
            if (label_ctr != nnot_pkg::LABEL_MAX)
                label_ctr = label_ctr + 1'b1;
        end
        else
            r.label = bank_lbl[pb][best_i];
        r.is_new = fresh;
        r.dsq    = (best > int'(nnot_pkg::DIST_MAX)) ? nnot_pkg::DIST_MAX :
                   nnot_pkg::DIST_W'(best);
        r.full   = (cur_n >= MAX_OBJ);
        if (!r.full)
        begin
            bank_x[cb][cur_n]   = x;
            bank_y[cb][cur_n]   = y;
            bank_lbl[cb][cur_n] = r.label;
            cur_n++;
        end
    endtask

    task automatic close_frame();
        prev_n   = cur_n;
        cur_n    = 0;
        bank_sel = ~bank_sel;
    endtask

    // valid is left high on return so back-to-back beats never drop it
    task automatic send_beat(input logic kind_op, input logic [COORD_W-1:0] x,
                             input logic [COORD_W-1:0] y, input bit known,
                             input track_res_t typed);
        int          gap;
        track_res_t  r;
        gap = pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        op       <= kind_op;
        obj_x    <= x;
        obj_y    <= y;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        if (kind_op == nnot_pkg::OP_OBJECT)
        begin
            track_object(x, y, r);
            expected_tracks.insert(expected_tracks.size(), known ? typed : r);
        end
        else
            close_frame();
        items_sent++;
    endtask

    // hold the sender until every result is back and any end of frame has retired
    task automatic settle();
        in_valid <= 1'b0;
        while (expected_tracks.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [nnot_pkg::CFG_IDX_W-1:0] idx,
                             input logic [nnot_pkg::CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (idx)
            nnot_pkg::CFG_INLET_X:   inlet_q = data[nnot_pkg::INLET_W-1:0];
            nnot_pkg::CFG_NEAR_GATE: near_q  = data[nnot_pkg::GATE_W-1:0];
            nnot_pkg::CFG_FAR_GATE:  far_q   = data[nnot_pkg::GATE_W-1:0];
            default:                 ;
        endcase
    endtask

    function automatic logic [nnot_pkg::CFG_DATA_W-1:0] pick_gate();
        logic [nnot_pkg::CFG_DATA_W-1:0] v;
        int r;
        r = $urandom_range(0, 9);
        if (r == 0)
            v = '0;
        else if (r == 1)
            v = 12'd255;
        else if (r < 7)
            v = 12'($urandom_range(0, 40));
        else
            v = 12'($urandom_range(0, 255));
        // unused upper bits now and then
        if ($urandom_range(0, 3) == 0)
            v[nnot_pkg::CFG_DATA_W-1:nnot_pkg::GATE_W] = 4'($urandom_range(0, 15));
        return v;
    endfunction

    task automatic program_regs();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0)
            write_reg(nnot_pkg::CFG_INLET_X, '0);
        else if (r == 1)
            write_reg(nnot_pkg::CFG_INLET_X, 12'hFFF);
        else
            write_reg(nnot_pkg::CFG_INLET_X, 12'($urandom));
        write_reg(nnot_pkg::CFG_NEAR_GATE, pick_gate());
        write_reg(nnot_pkg::CFG_FAR_GATE, pick_gate());
        cfg_valid <= 1'b0;
    endtask

    // most points sit on or near a stored centroid so labels carry over
    function automatic void pick_point(output logic [COORD_W-1:0] x,
                                       output logic [COORD_W-1:0] y);
        int pb;
        int idx;
        int r;
        pb = bank_sel ? 0 : 1;
        r  = $urandom_range(0, 99);
        x  = COORD_W'($urandom);
        y  = COORD_W'($urandom);
        if (prev_n != 0 && r < 80)
        begin
            idx = $urandom_range(0, prev_n - 1);
            x   = bank_x[pb][idx];
            y   = bank_y[pb][idx];
            if (r >= 10)
            begin
                x = x + COORD_W'($urandom_range(0, 60)) - 12'd30;
                y = y + COORD_W'($urandom_range(0, 60)) - 12'd30;
            end
        end
        else if (r < 88)
            x = inlet_q - 12'd6 + COORD_W'($urandom_range(0, 2));
    endfunction

    function automatic stim_row_t obj_row(logic [COORD_W-1:0] x, logic [COORD_W-1:0] y);
        stim_row_t r;
        r.kind  = ROW_OBJECT;
        r.x     = x;
        r.y     = y;
        r.idx   = '0;
        r.data  = '0;
        r.known = 1'b0;
        r.res   = '0;
        return r;
    endfunction

    function automatic stim_row_t known_row(logic [COORD_W-1:0] x, logic [COORD_W-1:0] y,
                                            logic [nnot_pkg::LABEL_W-1:0] lbl, logic fresh,
                                            logic [nnot_pkg::DIST_W-1:0] dsq);
        stim_row_t r;
        r       = obj_row(x, y);
        r.known = 1'b1;
        r.res   = '{label: lbl, is_new: fresh, dsq: dsq, full: 1'b0};
        return r;
    endfunction

    function automatic stim_row_t eof_row();
        stim_row_t r;
        r      = obj_row(12'hFFF, 12'hFFF);
        r.kind = ROW_EOF;
        return r;
    endfunction

    function automatic stim_row_t cfg_row(logic [nnot_pkg::CFG_IDX_W-1:0] idx,
                                          logic [nnot_pkg::CFG_DATA_W-1:0] data);
        stim_row_t r;
        r      = obj_row('0, '0);
        r.kind = ROW_CONFIG;
        r.idx  = idx;
        r.data = data;
        return r;
    endfunction

    // result side: random stall and in-order compare
    always @(posedge clk)
    begin : result_check
        track_res_t want;
        int         n;
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_tracks.size() == 0)
                begin
                    $error("result beat with nothing expected: track_label %0d", track_label);
                    fail_count++;
                end
                else
                begin
                    want = expected_tracks.pop_front();
                    if (track_label !== want.label)
                    begin
                        $error("track_label: expected %0d, got %0d", want.label, track_label);
                        fail_count++;
                    end
                    if (is_new !== want.is_new)
                    begin
                        $error("is_new: expected %0d, got %0d", want.is_new, is_new);
                        fail_count++;
                    end
                    if (nearest_dist_sq !== want.dsq)
                    begin
                        $error("nearest_dist_sq: expected %0d, got %0d", want.dsq,
                               nearest_dist_sq);
                        fail_count++;
                    end
                    if (table_full !== want.full)
                    begin
                        $error("table_full: expected %0d, got %0d", want.full, table_full);
                        fail_count++;
                    end
                end
            end
            if (stall_left > 0)
            begin
                stall_left--;
                out_stall <= 1'b1;
            end
            else
            begin
                n = pick_gap();
                out_stall  <= (n > 0);
                stall_left = (n > 0) ? n - 1 : 0;
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    initial
    begin : stimulus
        logic [COORD_W-1:0] px;
        logic [COORD_W-1:0] py;
        int                 n;
        int                 r;
        int                 frame_cnt;

        rst_n     = 1'b0;
        in_valid  = 1'b0;
        op        = nnot_pkg::OP_OBJECT;
        obj_x     = '0;
        obj_y     = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        frame_cnt = 0;

        // reset gates: near 5, far 20, inlet 0
        plan.insert(plan.size(), known_row(12'd0, 12'd0, 16'd0, 1'b1, 25'd0));
        plan.insert(plan.size(), known_row(12'hFFF, 12'hFFF, 16'd1, 1'b1, 25'd0));
        plan.insert(plan.size(), known_row(12'd0, 12'hFFF, 16'd2, 1'b1, 25'd0));
        plan.insert(plan.size(), eof_row());
        plan.insert(plan.size(), known_row(12'hFFF, 12'hFFF, 16'd1, 1'b0, 25'd0));
        // right on the gate
        plan.insert(plan.size(), known_row(12'd20, 12'd0, 16'd0, 1'b0, 25'd400));
        // just past it
        plan.insert(plan.size(), known_row(12'd0, 12'd21, 16'd3, 1'b1, 25'd441));
        plan.insert(plan.size(), eof_row());
        plan.insert(plan.size(), eof_row());                        // empty frame
        plan.insert(plan.size(), known_row(12'd100, 12'd100, 16'd4, 1'b1, 25'd0));
        plan.insert(plan.size(), known_row(12'd104, 12'd100, 16'd5, 1'b1, 25'd0));
        plan.insert(plan.size(), eof_row());
        // tie, first wins
        plan.insert(plan.size(), known_row(12'd102, 12'd100, 16'd4, 1'b0, 25'd4));
        plan.insert(plan.size(), cfg_row(nnot_pkg::CFG_INLET_X, 12'hFFF));
        plan.insert(plan.size(), cfg_row(nnot_pkg::CFG_NEAR_GATE, 12'hF00));
        plan.insert(plan.size(), cfg_row(nnot_pkg::CFG_FAR_GATE, 12'h0FF));
        plan.insert(plan.size(), cfg_row(CFG_SPARE, 12'hFFF));
        // zero gate, exact hit
        plan.insert(plan.size(), known_row(12'd100, 12'd100, 16'd4, 1'b0, 25'd0));
        plan.insert(plan.size(), obj_row(12'd101, 12'd100));
        plan.insert(plan.size(), eof_row());
        plan.insert(plan.size(), cfg_row(nnot_pkg::CFG_INLET_X, 12'd0));
        plan.insert(plan.size(), obj_row(12'hFFF, 12'hFFF));
        plan.insert(plan.size(), eof_row());
        // widest distance
        plan.insert(plan.size(), known_row(12'd0, 12'd0, 16'd8, 1'b1, 25'd33538050));
        plan.insert(plan.size(), obj_row(12'hFFF, 12'd3840));       // widest gate
        plan.insert(plan.size(), cfg_row(nnot_pkg::CFG_INLET_X, 12'd105));
        plan.insert(plan.size(), eof_row());
        plan.insert(plan.size(), obj_row(12'd100, 12'd0));   // last x on the near side
        plan.insert(plan.size(), obj_row(12'd101, 12'd0));   // first x on the far side

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (plan[i])
        begin
            if (plan[i].kind == ROW_CONFIG)
            begin
                if (!cfg_open)
                begin
                    settle();
                    cfg_open = 1'b1;
                end
                write_reg(plan[i].idx, plan[i].data);
            end
            else
            begin
                if (cfg_open)
                begin
                    cfg_valid <= 1'b0;
                    cfg_open  = 1'b0;
                end
                send_beat((plan[i].kind == ROW_EOF) ? nnot_pkg::OP_EOF : nnot_pkg::OP_OBJECT,
                          plan[i].x, plan[i].y, plan[i].known, plan[i].res);
            end
        end

        // random frames, mostly small, a few past the bank size
        while (items_sent < TOTAL_ITEMS)
        begin
            frame_cnt++;
            calm = ($urandom_range(0, 4) == 0);
            if (frame_cnt % 7 == 1 || $urandom_range(0, 9) == 0)
            begin
                settle();
                program_regs();
            end
            else if ($urandom_range(0, 9) == 0)
                settle();
            r = $urandom_range(0, 99);
            if (r < 5)
                n = 0;
            else if (r < 85)
                n = $urandom_range(1, 8);
            else if (r < 95)
                n = $urandom_range(9, 20);
            else
                n = $urandom_range(MAX_OBJ - 2, MAX_OBJ + 4);
            for (int j = 0; j < n; j++)
            begin
                pick_point(px, py);
                send_beat(nnot_pkg::OP_OBJECT, px, py, 1'b0, '0);
            end
            send_beat(nnot_pkg::OP_EOF, COORD_W'($urandom), COORD_W'($urandom), 1'b0, '0);
        end

        calm = 1'b0;
        for (int j = 0; j < 20; j++)
        begin
            pick_point(px, py);
            send_beat(nnot_pkg::OP_OBJECT, px, py, 1'b0, '0);
        end
        send_beat(nnot_pkg::OP_EOF, '0, '0, 1'b0, '0);

        in_valid <= 1'b0;
        while (expected_tracks.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
